// ===== rtl/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, codes and the base64 alphabet lookup for the stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_PLUS    = 8'h2B;
  localparam logic [7:0] ASCII_SLASH   = 8'h2F;
  localparam logic [7:0] ASCII_PAD     = 8'h3D;

  localparam logic [1:0] PHASE_0 = 2'd0;
  localparam logic [1:0] PHASE_1 = 2'd1;
  localparam logic [1:0] PHASE_2 = 2'd2;

  typedef struct packed {
    logic       pad;
    logic [5:0] sextet;
  } sym_t;

  // One encoded byte: up to four symbols, index of the last one, end mark.
  typedef struct packed {
    logic [1:0]     last_idx;
    sym_t [3:0]     sym;
    logic           fin;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] b64_char(input sym_t s);
    logic [7:0] v;
    v = {2'b00, s.sextet};
    if (s.pad) begin
      b64_char = ASCII_PAD;
    end else if (v < 8'd26) begin
      b64_char = ASCII_UPPER_A + v;
    end else if (v < 8'd52) begin
      b64_char = ASCII_LOWER_A + (v - 8'd26);
    end else if (v < 8'd62) begin
      b64_char = ASCII_ZERO + (v - 8'd52);
    end else if (v == 8'd62) begin
      b64_char = ASCII_PLUS;
    end else begin
      b64_char = ASCII_SLASH;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/b64e_front.sv =====
// ----------------------------------------------------------------------------
// b64e_front
// Accepts message bytes, tracks the group phase and leftover bits, and
// splits each byte into a job of base64 symbols for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front
  import b64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // data_byte[7:0]
  input  wire logic       in_tlast,   // final_byte
  input  wire logic       q_full,
  output logic            q_push,
  output job_t            q_job
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;
  sym_t       pad_sym;

  assign pad_sym   = '{pad: 1'b1, sextet: 6'd0};
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_job     = '0;
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    unique case (phase_r)
      PHASE_1: begin
        q_job.sym[0] = '{pad: 1'b0, sextet: {carry_r[1:0], in_tdata[7:4]}};
        if (in_tlast) begin
          q_job.sym[1]  = '{pad: 1'b0, sextet: {in_tdata[3:0], 2'b00}};
          q_job.sym[2]  = pad_sym;
          q_job.last_idx = 2'd2;
          q_job.fin      = 1'b1;
          phase_nxt      = PHASE_0;
          carry_nxt      = 4'd0;
        end else begin
          q_job.last_idx = 2'd0;
          phase_nxt      = PHASE_2;
          carry_nxt      = in_tdata[3:0];
        end
      end
      PHASE_2: begin
        q_job.sym[0]   = '{pad: 1'b0, sextet: {carry_r, in_tdata[7:6]}};
        q_job.sym[1]   = '{pad: 1'b0, sextet: in_tdata[5:0]};
        q_job.last_idx = 2'd1;
        q_job.fin      = in_tlast;
        phase_nxt      = PHASE_0;
        carry_nxt      = 4'd0;
      end
      default: begin
        q_job.sym[0] = '{pad: 1'b0, sextet: in_tdata[7:2]};
        if (in_tlast) begin
          q_job.sym[1]   = '{pad: 1'b0, sextet: {in_tdata[1:0], 4'b0000}};
          q_job.sym[2]   = pad_sym;
          q_job.sym[3]   = pad_sym;
          q_job.last_idx = 2'd3;
          q_job.fin      = 1'b1;
          phase_nxt      = PHASE_0;
          carry_nxt      = 4'd0;
        end else begin
          q_job.last_idx = 2'd0;
          phase_nxt      = PHASE_1;
          carry_nxt      = {2'b00, in_tdata[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_0;
      carry_r <= 4'd0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b64e_queue.sv =====
// ----------------------------------------------------------------------------
// b64e_queue
// Small job queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_queue
  import b64e_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head_job,
  output q_stat_t   stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b64e_back.sv =====
// ----------------------------------------------------------------------------
// b64e_back
// Walks the symbols of the head job, maps them to ASCII and drives the
// registered output word.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back
  import b64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire job_t       head_job,
  input  wire logic       q_empty,
  output logic            q_pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // out_char[7:0]
  output logic            out_tlast   // out_last
);

  logic [1:0] idx_r;
  logic       valid_r;
  logic [7:0] data_r;
  logic       last_r;
  logic       load;
  logic       at_end;

  assign load       = !q_empty && (!valid_r || out_tready);
  assign at_end     = (idx_r == head_job.last_idx);
  assign q_pop      = load && at_end;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= b64_char(head_job.sym[idx_r]);
      last_r <= head_job.fin && at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= at_end ? 2'd0 : idx_r + 2'd1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/base64_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Standard base64 encoder: one byte in, one ASCII character out per word.
// ----------------------------------------------------------------------------
// Bytes enter on the in_ stream, in_tlast marking the last byte of a message;
// characters leave on the out_ stream, one per cycle while jobs are queued
// and out_tready is high, with out_tlast on the final character. Each byte
// yields one or two characters (1, 1, 2 over a three-byte group); a final
// byte yields up to four, '=' padded to a four-character boundary.
// Throughput is set by the single-character output register. The front end
// takes a byte every cycle while the QUEUE_DEPTH-entry job queue has room.
`default_nettype none

module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // data_byte[7:0]
  input  wire logic       in_tlast,   // final_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // out_char[7:0]
  output logic            out_tlast   // out_last
);

  job_t    push_job, head_job;
  logic    q_push, q_pop;
  q_stat_t q_stat;

  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_stat.full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_job   (head_job),
    .q_empty    (q_stat.empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_queue_stat : assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("push into full queue");

  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_last_pops : assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && head_job.fin) |=> (out_tvalid && out_tlast))
    else $error("end of message not marked on output");

endmodule

`default_nettype wire

// ===== dv/base64_stream_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder_tb
// Self-checking bench for the streaming base64 encoder.
// ----------------------------------------------------------------------------
// Bytes go in as whole messages, with in_tlast on the final byte. A behavioral
// encoder tracks the group phase and the leftover bits, and queues the
// characters that each accepted byte must produce. Every output word is
// compared with the oldest queued character, both char and end mark. The run
// covers boundary bytes and padding cases, random messages under four
// sender/receiver idle patterns, and a long output hold-off that stalls input.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder_tb
  import b64e_pkg::*;
;

  localparam logic [511:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 80;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // data_byte[7:0]
  logic       in_tlast   = 1'b0;   // final_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // out_char[7:0]
  logic       out_tlast;           // out_last

  enc_char_t  pending_chars[$];
  logic [1:0] enc_phase = PHASE_0;
  logic [3:0] enc_carry = 4'd0;

  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int rx_hold_req   = 0;
  int rx_hold_left  = 0;
  int stall_cycles  = 0;
  int errors        = 0;
  int bytes_sent    = 0;
  int msgs_sent     = 0;
  int chars_checked = 0;

  base64_stream_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    return B64_ALPHABET[8 * (63 - int'(s)) +: 8];
  endfunction

  function automatic void push_char(input logic [7:0] ch, input logic last);
    enc_char_t c;
    c.ch   = ch;
    c.last = last;
    pending_chars.push_back(c);
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    if (enc_phase == PHASE_1) begin
      push_char(sextet_char({enc_carry[1:0], b[7:4]}), 1'b0);
      enc_carry = b[3:0];
      if (fin) begin
        push_char(sextet_char({enc_carry, 2'b00}), 1'b0);
        push_char(ASCII_PAD, 1'b1);
        enc_phase = PHASE_0;
        enc_carry = 4'd0;
      end else begin
        enc_phase = PHASE_2;
      end
    end else if (enc_phase == PHASE_2) begin
      push_char(sextet_char({enc_carry, b[7:6]}), 1'b0);
      push_char(sextet_char(b[5:0]), fin);
      enc_phase = PHASE_0;
      enc_carry = 4'd0;
    end else begin
      push_char(sextet_char(b[7:2]), 1'b0);
      enc_carry = {2'b00, b[1:0]};
      if (fin) begin
        push_char(sextet_char({enc_carry[1:0], 4'b0000}), 1'b0);
        push_char(ASCII_PAD, 1'b0);
        push_char(ASCII_PAD, 1'b1);
        enc_phase = PHASE_0;
        enc_carry = 4'd0;
      end else begin
        enc_phase = PHASE_1;
      end
    end
  endfunction

  // Receiver: honor a requested hold-off first, then random stalls.
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin : check_word
      enc_char_t want;
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual char 0x%02h last %0b",
                 $time, out_tdata, out_tlast);
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (out_tdata !== want.ch) begin
          errors++;
          $display("%0t: char mismatch: expected 0x%02h, actual 0x%02h",
                   $time, want.ch, out_tdata);
        end
        if (out_tlast !== want.last) begin
          errors++;
          $display("%0t: end mark mismatch: expected %0b, actual %0b",
                   $time, want.last, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (pending_chars.size() == 0 && !in_tvalid)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d chars outstanding",
               $time, STALL_LIMIT, pending_chars.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    @(negedge clk);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    encode_byte(b, fin);
    bytes_sent++;
    if (fin) msgs_sent++;
  endtask

  task automatic send_random_message(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle(input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  task automatic test_directed;
    logic [7:0] vec[22] = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                            8'h00, 8'h00, 8'h00, 8'h4D, 8'h61, 8'h6E,
                            8'hFB, 8'hEF, 8'hBE, 8'h14, 8'hFB, 8'h9C,
                            8'h03, 8'hD9, 8'h7E};
    logic       fin[22] = '{1, 1, 0, 1, 0, 0, 1, 0, 0, 1, 0, 0, 1,
                            0, 0, 1, 0, 0, 0, 0, 0, 1};
    set_idle(0, 0);
    for (int i = 0; i < 22; i++) send_byte(vec[i], fin[i]);
    drain();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_bytes);
    int start;
    int len;
    set_idle(tx_pct, rx_pct);
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(16, 10) : $urandom_range(7, 1);
      send_random_message(len);
    end
    drain();
  endtask

  task automatic test_output_holdoff;
    set_idle(0, 0);
    rx_hold_req = HOLD_CYCLES;
    send_random_message(16);
    send_random_message(5);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_traffic(0, 0, 20);
    test_random_traffic(52, 0, 25);
    test_random_traffic(0, 52, 25);
    test_random_traffic(12, 12, 25);
    test_output_holdoff();

    $display("Covered %0d messages, %0d bytes, %0d characters checked,", msgs_sent,
             bytes_sent, chars_checked);
    $display("under four idle patterns and one %0d-cycle output hold-off.", HOLD_CYCLES);
    if (errors == 0 && pending_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder.sv
dv/base64_stream_encoder_tb.sv
